@@ design/assert_macros.svh @@
// Assertion macros for the checker file mtsw_checker.sv.
// No dependencies; pulled in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define ASSERT_CLKD(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Clocked property that also holds across reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

@@ design/mtsw_pkg.sv @@
// Package for the multi-target string waiter: sizes, codes and item types.
// No dependencies.
`timescale 1ns / 1ps

package mtsw_pkg;

  localparam int NUM_TARGETS = 4;
  localparam int MAX_LEN     = 8;

  localparam int NUM_CHAR_REGS = 4;
  localparam int WIN_BYTES     = 8;
  localparam int TGT_CNT = (NUM_TARGETS < NUM_CHAR_REGS) ? NUM_TARGETS : NUM_CHAR_REGS;
  localparam int LEN_CAP = (MAX_LEN < WIN_BYTES) ? MAX_LEN : WIN_BYTES;

  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_BEGIN = 2'd2;

  localparam logic [1:0] ST_WAITING = 2'd0;
  localparam logic [1:0] ST_MATCHED = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_IDLE    = 2'd3;

  localparam logic [2:0] CFG_CHARS_A = 3'd0;
  localparam logic [2:0] CFG_CHARS_B = 3'd1;
  localparam logic [2:0] CFG_CHARS_C = 3'd2;
  localparam logic [2:0] CFG_CHARS_D = 3'd3;
  localparam logic [2:0] CFG_LENGTHS = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT = 3'd5;

  typedef logic [NUM_CHAR_REGS-1:0][63:0] chars_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] wait_status;
    logic [1:0] match_index;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] index;
  } match_t;

endpackage

@@ design/mtsw_match.sv @@
// Parallel tail compare of the character window against all enabled targets.
// Depends on mtsw_pkg.
`timescale 1ns / 1ps

module mtsw_match (
  input  logic [63:0]     window,
  input  mtsw_pkg::chars_t chars,
  input  logic [15:0]     lengths,
  output mtsw_pkg::match_t match
);
  import mtsw_pkg::*;

  logic [TGT_CNT-1:0] hit;

  always_comb begin
    logic [3:0] len;
    logic       all_eq;
    for (int i = 0; i < TGT_CNT; i++) begin
      len    = lengths[4*i +: 4];
      all_eq = 1'b1;
      for (int k = 0; k < WIN_BYTES; k++) begin
        if ((4'(k) < len) && (window[8*k +: 8] != chars[i][8*k +: 8])) begin
          all_eq = 1'b0;
        end
      end
      hit[i] = (len != 4'd0) && (len <= 4'(LEN_CAP)) && all_eq;
    end
  end

  // lowest index wins
  always_comb begin
    match = '0;
    for (int i = TGT_CNT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        match.hit   = 1'b1;
        match.index = 2'(i);
      end
    end
  end

endmodule

@@ design/multi_target_string_waiter.sv @@
// Multi-target string waiter: input register, one pass of compare logic, result register.
// An accepted item waits in the input register; its result is registered once the output can advance.
// Throughput: one item per cycle unless a stalled result blocks it; shift and compare are combinational.
// Reset (rst, synchronous, active high): empty pipeline, no wait active, window,
// tick count and all configuration registers cleared to zero.
`timescale 1ns / 1ps

module multi_target_string_waiter (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  mtsw_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output mtsw_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import mtsw_pkg::*;

  chars_t      target_chars;
  logic [15:0] target_lengths;
  logic [15:0] timeout_ticks;

  logic [63:0] char_window, char_window_next;
  logic [15:0] tick_count, tick_count_next, tick_inc;
  logic        waiting, waiting_next;

  logic        stage_valid;
  item_t       stage_item;
  logic        advance;
  logic        load;
  logic        fire;
  logic [63:0] shifted;
  match_t      match;
  result_t     res_next;

  assign cfg_ready  = 1'b1;
  assign advance    = !result_valid || !result_stall;
  assign item_stall = stage_valid && !advance;
  assign load       = item_valid && !item_stall;
  assign fire       = stage_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_chars   <= '0;
      target_lengths <= '0;
      timeout_ticks  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHARS_A: target_chars[0] <= cfg_data;
        CFG_CHARS_B: target_chars[1] <= cfg_data;
        CFG_CHARS_C: target_chars[2] <= cfg_data;
        CFG_CHARS_D: target_chars[3] <= cfg_data;
        CFG_LENGTHS: target_lengths  <= cfg_data[15:0];
        CFG_TIMEOUT: timeout_ticks   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign shifted = {char_window[55:0], stage_item.rx_byte};

  mtsw_match u_match (
    .window  (shifted),
    .chars   (target_chars),
    .lengths (target_lengths),
    .match   (match)
  );

  assign tick_inc = (tick_count == 16'hFFFF) ? tick_count : tick_count + 16'd1;

  always_comb begin
    char_window_next = char_window;
    tick_count_next  = tick_count;
    waiting_next     = waiting;
    res_next         = '0;
    res_next.wait_status = ST_WAITING;
    if (stage_item.operation == OP_BEGIN) begin
      char_window_next = '0;
      tick_count_next  = '0;
      waiting_next     = 1'b1;
    end else if (!waiting) begin
      res_next.wait_status = ST_IDLE;
    end else begin
      case (stage_item.operation)
        OP_BYTE: begin
          char_window_next = shifted;
          if (match.hit) begin
            waiting_next         = 1'b0;
            res_next.wait_status = ST_MATCHED;
            res_next.match_index = match.index;
          end
        end
        OP_TICK: begin
          tick_count_next = tick_inc;
          if ((timeout_ticks != 16'd0) && (tick_inc >= timeout_ticks)) begin
            waiting_next         = 1'b0;
            res_next.wait_status = ST_TIMEOUT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
      char_window  <= '0;
      tick_count   <= '0;
      waiting      <= 1'b0;
    end else begin
      if (load) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= stage_valid;
      end
      if (fire) begin
        char_window <= char_window_next;
        tick_count  <= tick_count_next;
        waiting     <= waiting_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_item <= item;
    end
    if (fire) begin
      result <= res_next;
    end
  end

endmodule

@@ design/mtsw_checker.sv @@
// Port-level checker for multi_target_string_waiter, bound to the top level.
// Depends on mtsw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtsw_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input mtsw_pkg::result_t result
);
  import mtsw_pkg::*;

  `ASSERT_CLKD(a_result_hold, clk, rst,
    result_valid && result_stall |=> result_valid && $stable(result), "stalled result changed")
  `ASSERT_CLKD(a_index_zero, clk, rst,
    result_valid && (result.wait_status != ST_MATCHED) |-> result.match_index == 2'd0,
    "match index set without a match")
  `ASSERT_CLKD(a_stall_cause, clk, rst,
    item_stall |-> result_valid && result_stall, "input stalled while output is free")
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result shown right after reset")

endmodule

bind multi_target_string_waiter mtsw_checker u_mtsw_checker (.*);
